// ===== hw/rtl/tbms_pkg.sv =====
// Shared types, codes and helpers of the token bus master sequencer.
package tbms_pkg;

    localparam int TIMER_BITS = 24;
    localparam int TICK_BITS  = 24;
    localparam int ADDR_BITS  = 8;
    localparam logic [32:0] TIMER_MAX_W = (33'd1 << TIMER_BITS) - 33'd1;

    localparam int S_TDATA_BITS = 16;
    localparam int S_TUSER_BITS = 3;
    localparam int M_TDATA_BITS = 24;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_START     = 3'd1,
        ACT_START_ECHO = 3'd2,
        ACT_GRANT     = 3'd3,
        ACT_CLIENT    = 3'd4,
        ACT_TOKEN_RET = 3'd5,
        ACT_ADDR_REQ  = 3'd6,
        ACT_RSVD      = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_TOKEN = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_START = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        REQ_NONE      = 3'd0,
        REQ_CLIENT    = 3'd1,
        REQ_TOKEN     = 3'd2,
        REQ_START     = 3'd3,
        REQ_DISCOVERY = 3'd4
    } tx_req_t;

    typedef enum logic [2:0] {
        RPT_OK         = 3'd0,
        RPT_TIMEOUT    = 3'd1,
        RPT_NO_PACKET  = 3'd2,
        RPT_CLIENT_GO  = 3'd3,
        RPT_TOKEN_TMO  = 3'd4,
        RPT_QUERY_DONE = 3'd5
    } report_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OWN_ADDR   = 2'd0,
        REG_START_TMO  = 2'd1,
        REG_GRANT_TMO  = 2'd2,
        REG_CLIENT_TMO = 2'd3
    } reg_idx_t;

    typedef enum logic [5:0] {
        ST_IDLE        = 6'b000001,
        ST_START       = 6'b000010,
        ST_SENDING     = 6'b000100,
        ST_WAIT_CLIENT = 6'b001000,
        ST_QUERY       = 6'b010000,
        ST_WAIT_REPLY  = 6'b100000
    } state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] own_address;
        logic [TICK_BITS-1:0] start_ticks;
        logic [TICK_BITS-1:0] grant_ticks;
        logic [TICK_BITS-1:0] client_ticks;
    } cfg_t;

    typedef struct packed {
        action_t              action;
        command_t             command;
        logic [ADDR_BITS-1:0] target_address;
        logic                 tx_queue_empty;
        logic                 rx_busy;
    } item_t;

    typedef struct packed {
        state_t                fsm;
        logic [TIMER_BITS-1:0] countdown;
        logic                  armed;
        logic                  pending;
    } seq_state_t;

    typedef struct packed {
        tx_req_t              tx_request;
        logic [ADDR_BITS-1:0] tx_address;
        logic                 report_valid;
        report_t              report_code;
        logic                 forward_request;
        logic                 handled;
        logic [2:0]           current_state;
    } result_t;

    function automatic logic [TIMER_BITS-1:0] load_ticks(input logic [TICK_BITS-1:0] ticks);
        logic [32:0] wide;
        logic [TIMER_BITS-1:0] v;
        begin
            wide = 33'(ticks);
            if (wide == 33'd0) begin
                v = TIMER_BITS'(1);
            end else if (wide > TIMER_MAX_W) begin
                v = TIMER_BITS'(TIMER_MAX_W);
            end else begin
                v = TIMER_BITS'(wide);
            end
            return v;
        end
    endfunction

    function automatic logic [2:0] state_code(input state_t s);
        logic [2:0] c;
        begin
            unique case (s)
                ST_IDLE:        c = 3'd0;
                ST_START:       c = 3'd1;
                ST_SENDING:     c = 3'd2;
                ST_WAIT_CLIENT: c = 3'd3;
                ST_QUERY:       c = 3'd4;
                ST_WAIT_REPLY:  c = 3'd5;
                default:        c = 3'd0;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== hw/rtl/tbms_cfg_regs.sv =====
// Configuration register bank of the token bus master sequencer.
module tbms_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbms_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tbms_pkg::TICK_BITS-1:0]    cfg_data,
    output tbms_pkg::cfg_t                    cfg
);

    tbms_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_address  <= '0;
            cfg_reg.start_ticks  <= tbms_pkg::TICK_BITS'(100);
            cfg_reg.grant_ticks  <= tbms_pkg::TICK_BITS'(10);
            cfg_reg.client_ticks <= tbms_pkg::TICK_BITS'(100);
        end else if (cfg_valid) begin
            unique case (tbms_pkg::reg_idx_t'(cfg_index))
                tbms_pkg::REG_OWN_ADDR:
                    cfg_reg.own_address <= cfg_data[tbms_pkg::ADDR_BITS-1:0];
                tbms_pkg::REG_START_TMO:  cfg_reg.start_ticks  <= cfg_data;
                tbms_pkg::REG_GRANT_TMO:  cfg_reg.grant_ticks  <= cfg_data;
                tbms_pkg::REG_CLIENT_TMO: cfg_reg.client_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/tbms_step.sv =====
// Next-state and result logic for one word of the sequencer.
module tbms_step (
    input  tbms_pkg::cfg_t       cfg,
    input  tbms_pkg::item_t      item,
    input  tbms_pkg::seq_state_t cur,
    output tbms_pkg::seq_state_t nxt,
    output tbms_pkg::result_t    res
);

    logic [tbms_pkg::TIMER_BITS-1:0] client_load;
    logic [tbms_pkg::TIMER_BITS-1:0] grant_load;
    logic [tbms_pkg::TIMER_BITS-1:0] start_load;
    logic                            finish_en;
    tbms_pkg::report_t               finish_code;

    assign client_load = tbms_pkg::load_ticks(cfg.client_ticks);
    assign grant_load  = tbms_pkg::load_ticks(cfg.grant_ticks);
    assign start_load  = tbms_pkg::load_ticks(cfg.start_ticks);

    always_comb begin
        nxt                 = cur;
        res.tx_request      = tbms_pkg::REQ_NONE;
        res.tx_address      = '0;
        res.report_valid    = 1'b0;
        res.report_code     = tbms_pkg::RPT_OK;
        res.forward_request = 1'b0;
        res.handled         = 1'b0;
        finish_en           = 1'b0;
        finish_code         = tbms_pkg::RPT_OK;

        unique case (item.action)
            tbms_pkg::ACT_TICK: begin
                if (cur.armed) begin
                    if (cur.countdown <= tbms_pkg::TIMER_BITS'(1)) begin
                        nxt.countdown = '0;
                        nxt.armed     = 1'b0;
                        res.handled   = 1'b1;
                        unique case (cur.fsm) inside
                            tbms_pkg::ST_START: begin
                                finish_en   = 1'b1;
                                finish_code = tbms_pkg::RPT_TIMEOUT;
                            end
                            tbms_pkg::ST_SENDING: begin
                                nxt.fsm = tbms_pkg::ST_IDLE;
                            end
                            tbms_pkg::ST_WAIT_CLIENT: begin
                                if (item.rx_busy) begin
                                    nxt.countdown = client_load;
                                    nxt.armed     = 1'b1;
                                end else begin
                                    finish_en   = 1'b1;
                                    finish_code = tbms_pkg::RPT_TOKEN_TMO;
                                end
                            end
                            tbms_pkg::ST_QUERY, tbms_pkg::ST_WAIT_REPLY: begin
                                if (item.rx_busy) begin
                                    nxt.countdown = client_load;
                                    nxt.armed     = 1'b1;
                                end else begin
                                    finish_en   = 1'b1;
                                    finish_code = tbms_pkg::RPT_QUERY_DONE;
                                end
                            end
                            default: begin
                                res.handled = 1'b0;
                                nxt.fsm     = tbms_pkg::ST_IDLE;
                            end
                        endcase
                    end else begin
                        nxt.countdown = cur.countdown - tbms_pkg::TIMER_BITS'(1);
                    end
                end
            end
            tbms_pkg::ACT_START: begin
                if (cur.fsm == tbms_pkg::ST_IDLE) begin
                    nxt.pending = (item.command != tbms_pkg::CMD_NONE);
                    res.handled = 1'b1;
                    unique case (item.command)
                        tbms_pkg::CMD_TOKEN: begin
                            if (item.target_address == cfg.own_address) begin
                                if (item.tx_queue_empty) begin
                                    finish_en   = 1'b1;
                                    finish_code = tbms_pkg::RPT_NO_PACKET;
                                end else begin
                                    res.tx_request = tbms_pkg::REQ_CLIENT;
                                    nxt.fsm        = tbms_pkg::ST_WAIT_CLIENT;
                                    nxt.countdown  = client_load;
                                    nxt.armed      = 1'b1;
                                end
                            end else begin
                                res.tx_request = tbms_pkg::REQ_TOKEN;
                                res.tx_address = item.target_address;
                                nxt.fsm        = tbms_pkg::ST_SENDING;
                                nxt.countdown  = grant_load;
                                nxt.armed      = 1'b1;
                            end
                        end
                        tbms_pkg::CMD_QUERY: begin
                            res.tx_request = tbms_pkg::REQ_DISCOVERY;
                            nxt.fsm        = tbms_pkg::ST_QUERY;
                            nxt.countdown  = client_load;
                            nxt.armed      = 1'b1;
                        end
                        tbms_pkg::CMD_START: begin
                            res.tx_request = tbms_pkg::REQ_START;
                            nxt.fsm        = tbms_pkg::ST_START;
                            nxt.countdown  = start_load;
                            nxt.armed      = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            tbms_pkg::ACT_START_ECHO: begin
                if (cur.fsm == tbms_pkg::ST_START) begin
                    res.handled = 1'b1;
                    finish_en   = 1'b1;
                    finish_code = tbms_pkg::RPT_OK;
                end
            end
            tbms_pkg::ACT_GRANT: begin
                if (cur.fsm == tbms_pkg::ST_SENDING) begin
                    res.handled   = 1'b1;
                    nxt.fsm       = tbms_pkg::ST_WAIT_CLIENT;
                    nxt.countdown = client_load;
                    nxt.armed     = 1'b1;
                end
            end
            tbms_pkg::ACT_CLIENT: begin
                if (cur.fsm == tbms_pkg::ST_WAIT_CLIENT) begin
                    res.handled = 1'b1;
                    finish_en   = 1'b1;
                    finish_code = tbms_pkg::RPT_CLIENT_GO;
                end
            end
            tbms_pkg::ACT_TOKEN_RET: begin
                if (cur.fsm == tbms_pkg::ST_WAIT_CLIENT) begin
                    res.handled = 1'b1;
                    finish_en   = 1'b1;
                    finish_code = tbms_pkg::RPT_NO_PACKET;
                end
            end
            tbms_pkg::ACT_ADDR_REQ: begin
                if (cur.fsm == tbms_pkg::ST_QUERY) begin
                    res.handled         = 1'b1;
                    res.forward_request = 1'b1;
                    nxt.fsm             = tbms_pkg::ST_WAIT_REPLY;
                    nxt.countdown       = client_load;
                    nxt.armed           = 1'b1;
                end
            end
            default: ;
        endcase

        // end the action: report only if one is pending
        if (finish_en) begin
            res.report_valid = nxt.pending;
            res.report_code  = nxt.pending ? finish_code : tbms_pkg::RPT_OK;
            nxt.pending      = 1'b0;
            nxt.fsm          = tbms_pkg::ST_IDLE;
        end

        // drop the timer on any return to idle
        if (nxt.fsm == tbms_pkg::ST_IDLE && cur.fsm != tbms_pkg::ST_IDLE) begin
            nxt.countdown = '0;
            nxt.armed     = 1'b0;
        end

        res.current_state = tbms_pkg::state_code(nxt.fsm);
    end

endmodule

// ===== hw/rtl/token_bus_master_sequencer_core.sv =====
// Top level of the token bus master sequencer: word registers, state and result stage.
//
//  channel | ports                        | word contents (lsb first)
//  --------+------------------------------+------------------------------------------------
//  in      | s_tvalid s_tready s_tdata    | tuser: action[2:0]
//          | s_tuser                      | tdata: command, target_address, tx_queue_empty,
//          |                              |        rx_busy, zero pad
//  out     | m_tvalid m_tready m_tdata    | tx_request, tx_address, report_valid,
//          |                              | report_code, forward_request, handled,
//          |                              | current_state, zero pad
//  config  | cfg_valid cfg_ready          | cfg_index selects the register, cfg_data value
//          | cfg_index cfg_data           |
//
// One word per cycle while the result register can drain; each word passes the input register,
// then the state update into the result register.
// aresetn clears state, pending flag, timer and both valid flags; config returns to defaults.
// A stalled result holds in place; the input register keeps taking words while the
// result register can drain.
module token_bus_master_sequencer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] command, [9:2] target_address, [10] tx_queue_empty, [11] rx_busy
    input  logic [tbms_pkg::S_TDATA_BITS-1:0] s_tdata,
    // [2:0] action
    input  logic [tbms_pkg::S_TUSER_BITS-1:0] s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] tx_request, [10:3] tx_address, [11] report_valid, [14:12] report_code,
    // [15] forward_request, [16] handled, [19:17] current_state
    output logic [tbms_pkg::M_TDATA_BITS-1:0] m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbms_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tbms_pkg::TICK_BITS-1:0]    cfg_data
);

    tbms_pkg::cfg_t       cfg;
    tbms_pkg::item_t      item_reg;
    logic                 in_valid_reg;
    tbms_pkg::seq_state_t state_reg;
    tbms_pkg::seq_state_t state_next;
    tbms_pkg::result_t    res_next;
    tbms_pkg::result_t    res_reg;
    logic                 m_tvalid_reg;
    logic                 advance;

    tbms_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbms_step u_step (
        .cfg  (cfg),
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tbms_pkg::M_TDATA_BITS'({
                          res_reg.current_state, res_reg.handled, res_reg.forward_request,
                          res_reg.report_code, res_reg.report_valid, res_reg.tx_address,
                          res_reg.tx_request});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.action         <= tbms_pkg::action_t'(s_tuser);
            item_reg.command        <= tbms_pkg::command_t'(s_tdata[1:0]);
            item_reg.target_address <= s_tdata[9:2];
            item_reg.tx_queue_empty <= s_tdata[10];
            item_reg.rx_busy        <= s_tdata[11];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.fsm       <= tbms_pkg::ST_IDLE;
            state_reg.countdown <= '0;
            state_reg.armed     <= 1'b0;
            state_reg.pending   <= 1'b0;
            m_tvalid_reg        <= 1'b0;
        end else if (advance) begin
            state_reg    <= state_next;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== verif/token_bus_master_sequencer_checker.sv =====
`timescale 1ns / 100ps
// Checker for the token bus master sequencer: predicts each result word and compares it.
module token_bus_master_sequencer_checker
    import tbms_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic [S_TUSER_BITS-1:0] s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_BITS-1:0] m_tdata,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [TICK_BITS-1:0]    cfg_data,
    output int                      outstanding,
    output int                      failures
);

    localparam logic [2:0] SC_IDLE        = 3'd0;
    localparam logic [2:0] SC_START       = 3'd1;
    localparam logic [2:0] SC_SENDING     = 3'd2;
    localparam logic [2:0] SC_WAIT_CLIENT = 3'd3;
    localparam logic [2:0] SC_QUERY       = 3'd4;
    localparam logic [2:0] SC_WAIT_REPLY  = 3'd5;

    logic [ADDR_BITS-1:0]  own_addr;
    logic [TICK_BITS-1:0]  start_ticks;
    logic [TICK_BITS-1:0]  grant_ticks;
    logic [TICK_BITS-1:0]  client_ticks;

    logic [2:0]            seq_state;
    logic [TIMER_BITS-1:0] ticks_left;
    logic                  timer_on;
    logic                  action_open;

    result_t               results_q[$];

    function automatic void load_timer(input logic [TICK_BITS-1:0] t);
        ticks_left = (t == '0) ? TIMER_BITS'(1) : TIMER_BITS'(t);
        timer_on   = 1'b1;
    endfunction

    function automatic void enter_idle();
        seq_state  = SC_IDLE;
        ticks_left = '0;
        timer_on   = 1'b0;
    endfunction

    function automatic void close_action(input report_t code, inout result_t r);
        r.report_valid = action_open;
        r.report_code  = action_open ? code : RPT_OK;
        action_open    = 1'b0;
        enter_idle();
    endfunction

    function automatic result_t step_sequencer(input item_t w);
        result_t r;
        r = '0;
        case (w.action)
            ACT_TICK: begin
                if (timer_on) begin
                    if (ticks_left <= 1) begin
                        ticks_left = '0;
                        timer_on   = 1'b0;
                        r.handled  = 1'b1;
                        case (seq_state) inside
                            SC_START:   close_action(RPT_TIMEOUT, r);
                            SC_SENDING: enter_idle();
                            SC_WAIT_CLIENT: begin
                                if (w.rx_busy) load_timer(client_ticks);
                                else close_action(RPT_TOKEN_TMO, r);
                            end
                            SC_QUERY, SC_WAIT_REPLY: begin
                                if (w.rx_busy) load_timer(client_ticks);
                                else close_action(RPT_QUERY_DONE, r);
                            end
                            default: begin
                                r.handled = 1'b0;
                                enter_idle();
                            end
                        endcase
                    end else begin
                        ticks_left = ticks_left - 1'b1;
                    end
                end
            end
            ACT_START: begin
                if (seq_state == SC_IDLE) begin
                    action_open = (w.command != CMD_NONE);
                    r.handled   = 1'b1;
                    case (w.command)
                        CMD_TOKEN: begin
                            if (w.target_address == own_addr) begin
                                if (w.tx_queue_empty) begin
                                    close_action(RPT_NO_PACKET, r);
                                end else begin
                                    r.tx_request = REQ_CLIENT;
                                    seq_state    = SC_WAIT_CLIENT;
                                    load_timer(client_ticks);
                                end
                            end else begin
                                r.tx_request = REQ_TOKEN;
                                r.tx_address = w.target_address;
                                seq_state    = SC_SENDING;
                                load_timer(grant_ticks);
                            end
                        end
                        CMD_QUERY: begin
                            r.tx_request = REQ_DISCOVERY;
                            seq_state    = SC_QUERY;
                            load_timer(client_ticks);
                        end
                        CMD_START: begin
                            r.tx_request = REQ_START;
                            seq_state    = SC_START;
                            load_timer(start_ticks);
                        end
                        default: ;
                    endcase
                end
            end
            ACT_START_ECHO: begin
                if (seq_state == SC_START) begin
                    r.handled = 1'b1;
                    close_action(RPT_OK, r);
                end
            end
            ACT_GRANT: begin
                if (seq_state == SC_SENDING) begin
                    r.handled = 1'b1;
                    seq_state = SC_WAIT_CLIENT;
                    load_timer(client_ticks);
                end
            end
            ACT_CLIENT: begin
                if (seq_state == SC_WAIT_CLIENT) begin
                    r.handled = 1'b1;
                    close_action(RPT_CLIENT_GO, r);
                end
            end
            ACT_TOKEN_RET: begin
                if (seq_state == SC_WAIT_CLIENT) begin
                    r.handled = 1'b1;
                    close_action(RPT_NO_PACKET, r);
                end
            end
            ACT_ADDR_REQ: begin
                if (seq_state == SC_QUERY) begin
                    r.handled         = 1'b1;
                    r.forward_request = 1'b1;
                    seq_state         = SC_WAIT_REPLY;
                    load_timer(client_ticks);
                end
            end
            default: ;
        endcase
        r.current_state = seq_state;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        item_t   w;
        result_t want;
        if (!aresetn) begin
            own_addr     = '0;
            start_ticks  = TICK_BITS'(100);
            grant_ticks  = TICK_BITS'(10);
            client_ticks = TICK_BITS'(100);
            seq_state    = SC_IDLE;
            ticks_left   = '0;
            timer_on     = 1'b0;
            action_open  = 1'b0;
            failures     = 0;
            results_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_q.size() == 0) begin
                    $error("result word with no expectation waiting");
                    failures++;
                end else begin
                    want = results_q.pop_front();
                    check_field("tx_request", want.tx_request, m_tdata[2:0]);
                    check_field("tx_address", want.tx_address, m_tdata[10:3]);
                    check_field("report_valid", want.report_valid, m_tdata[11]);
                    check_field("report_code", want.report_code, m_tdata[14:12]);
                    check_field("forward_request", want.forward_request, m_tdata[15]);
                    check_field("handled", want.handled, m_tdata[16]);
                    check_field("current_state", want.current_state, m_tdata[19:17]);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_OWN_ADDR:   own_addr     = cfg_data[ADDR_BITS-1:0];
                    REG_START_TMO:  start_ticks  = cfg_data;
                    REG_GRANT_TMO:  grant_ticks  = cfg_data;
                    REG_CLIENT_TMO: client_ticks = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                w.action         = action_t'(s_tuser[2:0]);
                w.command        = command_t'(s_tdata[1:0]);
                w.target_address = s_tdata[9:2];
                w.tx_queue_empty = s_tdata[10];
                w.rx_busy        = s_tdata[11];
                results_q.push_back(step_sequencer(w));
            end
        end
        outstanding <= results_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the sequencer testbench: clock, reset, bus event stimulus and verdict.
module testbench;
    import tbms_pkg::*;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;
    logic [S_TUSER_BITS-1:0] s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [TICK_BITS-1:0]    cfg_data  = '0;
    int                      outstanding;
    int                      failures;

    logic [ADDR_BITS-1:0]    own_mirror = '0;
    int                      words_sent = 0;
    int                      burst_left = 1;
    int                      burst_max  = 1;
    int                      gap_max    = 0;
    int                      tick_span  = 3;
    int                      stall_left = 0;
    int                      stall_pct  = 0;

    token_bus_master_sequencer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    token_bus_master_sequencer_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .failures    (failures)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if ($urandom_range(0, 255) == 0) begin
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                default: stall_pct = 60;
            endcase
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 5);
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_word(input action_t a, input command_t c, input logic [7:0] tgt,
                             input logic qe, input logic busy);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= S_TUSER_BITS'(a);
        s_tdata  <= {4'b0, busy, qe, tgt, c};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_register(input reg_idx_t idx, input logic [TICK_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [7:0] own, input logic [23:0] t_start,
                             input logic [23:0] t_grant, input logic [23:0] t_client);
        put_register(REG_OWN_ADDR, TICK_BITS'(own));
        put_register(REG_START_TMO, t_start);
        put_register(REG_GRANT_TMO, t_grant);
        put_register(REG_CLIENT_TMO, t_client);
        cfg_valid  <= 1'b0;
        own_mirror = own;
    endtask

    task automatic set_pace(input int bursts, input int gaps, input int span);
        burst_max  = bursts;
        gap_max    = gaps;
        tick_span  = span;
        burst_left = 1;
    endtask

    task automatic pass_ticks();
        int n;
        n = $urandom_range(0, tick_span);
        repeat (n) begin
            send_word(ACT_TICK, command_t'($urandom_range(0, 3)), 8'($urandom),
                      1'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic send_start(input command_t c, input logic [7:0] tgt, input logic qe);
        send_word(ACT_START, c, tgt, qe, 1'($urandom));
    endtask

    task automatic send_event(input action_t a);
        send_word(a, command_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                  1'($urandom));
    endtask

    task automatic run_exchange();
        logic [7:0] peer;
        peer = 8'($urandom);
        case ($urandom_range(0, 9)) inside
            0, 1: begin
                send_start(CMD_START, peer, 1'($urandom));
                pass_ticks();
                if ($urandom_range(0, 1)) send_event(ACT_START_ECHO);
                pass_ticks();
            end
            2, 3, 4: begin
                if (peer == own_mirror) peer = peer ^ 8'h01;
                send_start(CMD_TOKEN, peer, 1'($urandom));
                pass_ticks();
                if ($urandom_range(0, 3) != 0) send_event(ACT_GRANT);
                pass_ticks();
                case ($urandom_range(0, 2))
                    0:       send_event(ACT_CLIENT);
                    1:       send_event(ACT_TOKEN_RET);
                    default: pass_ticks();
                endcase
            end
            5: begin
                send_start(CMD_TOKEN, own_mirror, 1'($urandom));
                pass_ticks();
                if ($urandom_range(0, 1)) send_event(ACT_CLIENT);
                else send_event(ACT_TOKEN_RET);
            end
            6, 7: begin
                send_start(CMD_QUERY, peer, 1'($urandom));
                pass_ticks();
                if ($urandom_range(0, 3) != 0) send_event(ACT_ADDR_REQ);
                pass_ticks();
            end
            8: send_start(CMD_NONE, peer, 1'($urandom));
            default: begin
                repeat ($urandom_range(1, 3)) begin
                    send_word(action_t'($urandom_range(0, 7)), command_t'($urandom_range(0, 3)),
                              8'($urandom), 1'($urandom), 1'($urandom));
                end
            end
        endcase
    endtask

    task automatic run_random(input int count);
        int goal;
        goal = words_sent + count;
        while (words_sent < goal) run_exchange();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults
        set_pace(4, 3, 12);
        run_random(40);
        drain();

        configure(8'hFF, 24'd0, 24'd2, 24'd1);
        set_pace(3, 2, 0);
        send_word(ACT_RSVD, CMD_START, 8'hFF, 1'b1, 1'b1);
        send_word(ACT_TICK, CMD_NONE, 8'h00, 1'b0, 1'b0);
        send_start(CMD_NONE, 8'h00, 1'b0);
        send_start(CMD_START, 8'h00, 1'b0);
        send_start(CMD_TOKEN, 8'h00, 1'b0);
        send_event(ACT_START_ECHO);
        send_start(CMD_START, 8'hFF, 1'b1);
        send_word(ACT_TICK, CMD_NONE, 8'h00, 1'b0, 1'b1);
        send_start(CMD_TOKEN, 8'h00, 1'b0);
        send_word(ACT_TICK, CMD_NONE, 8'h00, 1'b0, 1'b0);
        send_word(ACT_TICK, CMD_NONE, 8'h00, 1'b0, 1'b0);
        send_start(CMD_TOKEN, 8'h5A, 1'b0);
        send_event(ACT_GRANT);
        send_event(ACT_CLIENT);
        send_start(CMD_TOKEN, 8'hA5, 1'b1);
        send_event(ACT_GRANT);
        send_event(ACT_TOKEN_RET);
        send_start(CMD_TOKEN, 8'hFF, 1'b1);
        send_start(CMD_TOKEN, 8'hFF, 1'b0);
        send_word(ACT_TICK, CMD_NONE, 8'h00, 1'b0, 1'b1);
        send_word(ACT_TICK, CMD_NONE, 8'h00, 1'b0, 1'b0);
        send_start(CMD_QUERY, 8'h00, 1'b0);
        send_event(ACT_ADDR_REQ);
        send_word(ACT_TICK, CMD_NONE, 8'h00, 1'b0, 1'b1);
        send_word(ACT_TICK, CMD_NONE, 8'h00, 1'b0, 1'b0);
        send_start(CMD_QUERY, 8'h00, 1'b0);
        send_word(ACT_TICK, CMD_NONE, 8'h00, 1'b0, 1'b0);
        drain();

        // back-to-back, shortest timeouts
        configure(8'h00, 24'd1, 24'd1, 24'd1);
        set_pace(1000, 0, 3);
        run_random(100);
        drain();

        configure(8'hFF, 24'd0, 24'd3, 24'd5);
        set_pace(3, 6, 7);
        run_random(50);
        drain();
        run_random(50);
        drain();

        configure(8'($urandom), 24'($urandom_range(1, 6)), 24'($urandom_range(1, 6)),
                  24'($urandom_range(1, 6)));
        set_pace(6, 2, 8);
        run_random(60);
        drain();

        // longest timeouts: timers never run out
        configure(8'($urandom), 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        set_pace(4, 3, 6);
        run_random(40);
        drain();

        configure(8'($urandom), 24'($urandom_range(1, 4)), 24'($urandom_range(1, 4)),
                  24'($urandom_range(1, 4)));
        set_pace(2, 8, 6);
        run_random(60);
        drain();

        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
